### rtl/bgl_pkg.sv
`default_nettype none
package bgl_pkg;

  // grid geometry
  localparam int GRID_SIZE  = 256;
  localparam int IDX_W      = $clog2(GRID_SIZE);
  localparam int HALF_W     = (IDX_W > 1) ? IDX_W - 1 : 1;
  localparam int BANK_AW    = 2 * HALF_W;
  localparam int BANK_DEPTH = 1 << BANK_AW;
  localparam int CELL_W     = 25;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(GRID_SIZE - 1);

  // queues
  localparam int FQ_DEPTH = 4;
  localparam int FQ_AW    = $clog2(FQ_DEPTH);
  localparam int FQ_CW    = $clog2(FQ_DEPTH + 1);
  localparam int OQ_DEPTH = 8;
  localparam int OQ_AW    = $clog2(OQ_DEPTH);
  localparam int OQ_CW    = $clog2(OQ_DEPTH + 1);

  // register indexes
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_MIN     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_MAX     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFORM_MIN   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DEFORM_MAX   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_AREA_SCALE   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DEFORM_SCALE = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE_READY  = 3'd6;

  // result status codes
  localparam logic [1:0] STATUS_OK        = 2'd0;
  localparam logic [1:0] STATUS_NOT_READY = 2'd1;
  localparam logic [1:0] STATUS_RANGE     = 2'd2;
  localparam logic [1:0] STATUS_EMPTY     = 2'd3;

  localparam logic CMD_WRITE = 1'b1;

  typedef struct packed {
    logic [19:0] area_min;
    logic [19:0] area_max;
    logic [15:0] deform_min;
    logic [15:0] deform_max;
    logic [31:0] area_scale;
    logic [31:0] deform_scale;
    logic        table_ready;
  } bgl_cfg_t;

  typedef struct packed {
    logic              wr;
    logic [1:0]        sts;
    logic [19:0]       aoff;
    logic [15:0]       doff;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic              wok;
    logic [CELL_W-1:0] cell_word;
  } bgl_item_t;

  // bank address of a cell: row and column with the parity bit dropped
  function automatic logic [BANK_AW-1:0] bank_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
    logic [IDX_W-1:0] rh;
    logic [IDX_W-1:0] ch;
    rh = r >> 1;
    ch = c >> 1;
    return {rh[HALF_W-1:0], ch[HALF_W-1:0]};
  endfunction

endpackage
`default_nettype wire

### rtl/bgl_ram.sv
`default_nettype none
module bgl_ram #(
  parameter int WIDTH = 25,
  parameter int DEPTH = 16384
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

### rtl/bgl_front.sv
`default_nettype none
module bgl_front
  import bgl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic        in_command,
  input  wire logic [19:0] in_area,
  input  wire logic [15:0] in_deform,
  input  wire logic [7:0]  in_cell_row,
  input  wire logic [7:0]  in_cell_col,
  input  wire logic [23:0] in_cell_value,
  input  wire logic        in_cell_valid,
  input  wire bgl_cfg_t    cfg,
  output bgl_item_t        head,
  output logic             head_vld,
  input  wire logic        pop
);

  bgl_item_t         fq_r [FQ_DEPTH];
  logic [FQ_AW-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [FQ_AW-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [FQ_CW-1:0]  cnt_r, cnt_nxt;
  logic              push;
  logic              outside;
  bgl_item_t         item;

  assign in_stall = (cnt_r == FQ_CW'(FQ_DEPTH));
  assign push     = in_valid && !in_stall;
  assign head_vld = (cnt_r != '0);
  assign head     = fq_r[rd_ptr_r];

  // classify: command decode, range and ready checks, offsets from the axis minima, cell write fields
  always_comb begin
    outside = (in_area < cfg.area_min) || (in_area > cfg.area_max) ||
              (in_deform < cfg.deform_min) || (in_deform > cfg.deform_max);
    item.wr   = (in_command == CMD_WRITE);
    if (!cfg.table_ready) begin
      item.sts = STATUS_NOT_READY;
    end else if (outside) begin
      item.sts = STATUS_RANGE;
    end else begin
      item.sts = STATUS_OK;
    end
    item.aoff = in_area - cfg.area_min;
    item.doff = in_deform - cfg.deform_min;
    item.row  = IDX_W'(in_cell_row);
    item.col  = IDX_W'(in_cell_col);
    item.wok  = (32'(in_cell_row) < 32'(GRID_SIZE)) &&
                (32'(in_cell_col) < 32'(GRID_SIZE));
    item.cell_word = {in_cell_valid, in_cell_value};
  end

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop  ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      fq_r[wr_ptr_r] <= item;
    end
  end

endmodule
`default_nettype wire

### rtl/bgl_back.sv
`default_nettype none
module bgl_back
  import bgl_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire bgl_cfg_t    cfg,
  input  wire bgl_item_t   head,
  input  wire logic        head_vld,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [23:0]      out_value,
  output logic [1:0]       out_status
);

  localparam logic [16:0] ONE_W = 17'h10000;

  // credit for result slots: lookups in flight plus results queued
  logic [OQ_CW-1:0] used_r, used_nxt;
  logic             pop_lk;
  logic             out_acc;

  // stage 1: coordinate products
  logic              s1_vld_r, s1_wr_r, s1_wok_r;
  logic [1:0]        s1_sts_r;
  logic [51:0]       s1_pa_r;
  logic [47:0]       s1_pd_r;
  logic [IDX_W-1:0]  s1_row_r, s1_col_r;
  logic [CELL_W-1:0] s1_cell_r;

  // stage 2: corners being read
  logic              s2_vld_r;
  logic [1:0]        s2_sts_r;
  logic [15:0]       s2_fa_r, s2_fd_r;
  logic              s2_d0_r, s2_d1_r, s2_a0_r, s2_a1_r;

  // stage 3: first blend products
  logic              s3_vld_r;
  logic [1:0]        s3_sts_r;
  logic [15:0]       s3_fd_r;
  logic [40:0]       s3_p00_r, s3_p10_r, s3_p01_r, s3_p11_r;

  // stage 4: row blends
  logic              s4_vld_r;
  logic [1:0]        s4_sts_r;
  logic [15:0]       s4_fd_r;
  logic [40:0]       s4_v0_r, s4_v1_r;

  // stage 5: final products
  logic              s5_vld_r;
  logic [1:0]        s5_sts_r;
  logic [57:0]       s5_q0_r, s5_q1_r;

  // coordinate split
  logic [IDX_W-1:0]  ai0, ai1, di0, di1;
  logic [15:0]       fa, fd;

  logic              bank_we [4];
  logic [BANK_AW-1:0] bank_ra [4];
  logic [CELL_W-1:0] bank_rd [4];
  logic [BANK_AW-1:0] wr_addr;

  logic [CELL_W-1:0] c00, c10, c01, c11;
  logic              all_vld;
  logic [16:0]       wa, wd;
  logic [58:0]       vsum;
  logic [26:0]       vrnd;
  logic [23:0]       vres;

  // output queue
  logic [25:0]       oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0]  oq_wp_r, oq_rp_r;
  logic [OQ_CW-1:0]  oq_cnt_r, oq_cnt_nxt;
  logic              oq_push;

  assign pop     = head_vld && (head.wr || (used_r < OQ_CW'(OQ_DEPTH)));
  assign pop_lk  = pop && !head.wr;
  assign out_acc = out_valid && !out_stall;

  always_comb begin
    used_nxt = used_r;
    if (pop_lk && !out_acc) begin
      used_nxt = used_r + 1'b1;
    end else if (out_acc && !pop_lk) begin
      used_nxt = used_r - 1'b1;
    end
  end

  // split fixed-point coordinates into clamped index and fraction
  always_comb begin
    if (s1_pa_r[51:24] >= 28'(GRID_SIZE - 1)) begin
      ai0 = LAST_IDX;
      fa  = '0;
    end else begin
      ai0 = s1_pa_r[24 +: IDX_W];
      fa  = s1_pa_r[23:8];
    end
    if (s1_pd_r[47:32] >= 16'(GRID_SIZE - 1)) begin
      di0 = LAST_IDX;
      fd  = '0;
    end else begin
      di0 = s1_pd_r[32 +: IDX_W];
      fd  = s1_pd_r[31:16];
    end
    ai1 = (ai0 == LAST_IDX) ? ai0 : ai0 + 1'b1;
    di1 = (di0 == LAST_IDX) ? di0 : di0 + 1'b1;
  end

  // four banks by row and column parity: the four corners never collide
  always_comb begin
    logic [1:0]       bsel;
    logic [IDX_W-1:0] rsel;
    logic [IDX_W-1:0] csel;
    wr_addr = bank_addr(s1_row_r, s1_col_r);
    for (int b = 0; b < 4; b++) begin
      bsel = 2'(b);
      rsel = (di0[0] == bsel[1]) ? di0 : di1;
      csel = (ai0[0] == bsel[0]) ? ai0 : ai1;
      bank_ra[b] = bank_addr(rsel, csel);
      bank_we[b] = s1_vld_r && s1_wr_r && s1_wok_r &&
                   ({s1_row_r[0], s1_col_r[0]} == bsel);
    end
  end

  for (genvar g = 0; g < 4; g++) begin : g_bank
    bgl_ram #(
      .WIDTH(CELL_W),
      .DEPTH(BANK_DEPTH)
    ) u_bank (
      .clk  (clk),
      .we   (bank_we[g]),
      .waddr(wr_addr),
      .wdata(s1_cell_r),
      .raddr(bank_ra[g]),
      .rdata(bank_rd[g])
    );
  end

  always_comb begin
    c00 = bank_rd[{s2_d0_r, s2_a0_r}];
    c10 = bank_rd[{s2_d0_r, s2_a1_r}];
    c01 = bank_rd[{s2_d1_r, s2_a0_r}];
    c11 = bank_rd[{s2_d1_r, s2_a1_r}];
    all_vld = c00[24] && c10[24] && c01[24] && c11[24];
    wa = ONE_W - {1'b0, s2_fa_r};
    wd = ONE_W - {1'b0, s4_fd_r};
  end

  // round half up, drop 32 fraction bits, saturate
  always_comb begin
    vsum = {1'b0, s5_q0_r} + {1'b0, s5_q1_r} + 59'h80000000;
    vrnd = vsum[58:32];
    vres = (vrnd > 27'hFFFFFF) ? 24'hFFFFFF : vrnd[23:0];
  end

  assign oq_push = s5_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
      s2_vld_r <= 1'b0;
      s3_vld_r <= 1'b0;
      s4_vld_r <= 1'b0;
      s5_vld_r <= 1'b0;
      used_r   <= '0;
    end else begin
      s1_vld_r <= pop;
      s2_vld_r <= s1_vld_r && !s1_wr_r;
      s3_vld_r <= s2_vld_r;
      s4_vld_r <= s3_vld_r;
      s5_vld_r <= s4_vld_r;
      used_r   <= used_nxt;
    end
  end

  always_ff @(posedge clk) begin
    s1_wr_r   <= head.wr;
    s1_wok_r  <= head.wok;
    s1_sts_r  <= head.sts;
    s1_pa_r   <= {32'b0, head.aoff} * {20'b0, cfg.area_scale};
    s1_pd_r   <= {32'b0, head.doff} * {16'b0, cfg.deform_scale};
    s1_row_r  <= head.row;
    s1_col_r  <= head.col;
    s1_cell_r <= head.cell_word;

    s2_sts_r <= s1_sts_r;
    s2_fa_r  <= fa;
    s2_fd_r  <= fd;
    s2_d0_r  <= di0[0];
    s2_d1_r  <= di1[0];
    s2_a0_r  <= ai0[0];
    s2_a1_r  <= ai1[0];

    s3_sts_r <= ((s2_sts_r == STATUS_OK) && !all_vld) ? STATUS_EMPTY : s2_sts_r;
    s3_fd_r  <= s2_fd_r;
    s3_p00_r <= {17'b0, c00[23:0]} * {24'b0, wa};
    s3_p10_r <= {17'b0, c10[23:0]} * {25'b0, s2_fa_r};
    s3_p01_r <= {17'b0, c01[23:0]} * {24'b0, wa};
    s3_p11_r <= {17'b0, c11[23:0]} * {25'b0, s2_fa_r};

    s4_sts_r <= s3_sts_r;
    s4_fd_r  <= s3_fd_r;
    s4_v0_r  <= s3_p00_r + s3_p10_r;
    s4_v1_r  <= s3_p01_r + s3_p11_r;

    s5_sts_r <= s4_sts_r;
    s5_q0_r  <= {17'b0, s4_v0_r} * {41'b0, wd};
    s5_q1_r  <= {17'b0, s4_v1_r} * {42'b0, s4_fd_r};
  end

  // result queue: credit keeps it from overflowing
  always_comb begin
    oq_cnt_nxt = oq_cnt_r;
    if (oq_push && !out_acc) begin
      oq_cnt_nxt = oq_cnt_r + 1'b1;
    end else if (out_acc && !oq_push) begin
      oq_cnt_nxt = oq_cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= '0;
      oq_rp_r  <= '0;
      oq_cnt_r <= '0;
    end else begin
      oq_wp_r  <= oq_push ? oq_wp_r + 1'b1 : oq_wp_r;
      oq_rp_r  <= out_acc ? oq_rp_r + 1'b1 : oq_rp_r;
      oq_cnt_r <= oq_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (oq_push) begin
      oq_r[oq_wp_r] <= {((s5_sts_r == STATUS_OK) ? vres : 24'h0), s5_sts_r};
    end
  end

  assign out_valid  = (oq_cnt_r != '0);
  assign out_value  = oq_r[oq_rp_r][25:2];
  assign out_status = oq_r[oq_rp_r][1:0];

endmodule
`default_nettype wire

### rtl/bilinear_grid_lookup.sv
`default_nettype none
// bilinear grid lookup: a 256 x 256 table of Q16.8 values, each with a valid
// flag, loaded by write items and read by bilinear interpolation on lookup
// items (area Q12.8, deformability Q0.16). one item is taken per cycle,
// writes and lookups mixed freely; each lookup gives one result item, a
// write gives none. from the four-entry input queue, a lookup passes the
// coordinate, corner read, blend and product stages into the eight-entry
// result queue, whose credit count caps the lookups in flight, so the block
// keeps one item per cycle as long as the result side takes one per cycle.
// four single-port-write banks split by row and column parity hold the grid,
// so the four corners of a cell are read in the same cycle. no clearing
// pass: every cell must be written before a lookup touches it, and
// table_ready set after loading. registers are to be written only while the
// block is idle; the block does not enforce this; cfg_ready is always high.
module bilinear_grid_lookup
  import bgl_pkg::*;
(
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  // input item channel
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 in_command,
  input  wire logic [19:0]          in_area,
  input  wire logic [15:0]          in_deform,
  input  wire logic [7:0]           in_cell_row,
  input  wire logic [7:0]           in_cell_col,
  input  wire logic [23:0]          in_cell_value,
  input  wire logic                 in_cell_valid,
  // result item channel
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [23:0]               out_value,
  output logic [1:0]                out_status,
  // register write channel
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  bgl_cfg_t  cfg_r;
  bgl_item_t head;
  logic      head_vld;
  logic      pop;

  assign cfg_ready = 1'b1;

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.area_min     <= '0;
      cfg_r.area_max     <= 20'hFFFFF;
      cfg_r.deform_min   <= '0;
      cfg_r.deform_max   <= 16'hFFFF;
      cfg_r.area_scale   <= '0;
      cfg_r.deform_scale <= '0;
      cfg_r.table_ready  <= 1'b0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_AREA_MIN:     cfg_r.area_min     <= cfg_data[19:0];
        REG_AREA_MAX:     cfg_r.area_max     <= cfg_data[19:0];
        REG_DEFORM_MIN:   cfg_r.deform_min   <= cfg_data[15:0];
        REG_DEFORM_MAX:   cfg_r.deform_max   <= cfg_data[15:0];
        REG_AREA_SCALE:   cfg_r.area_scale   <= cfg_data;
        REG_DEFORM_SCALE: cfg_r.deform_scale <= cfg_data;
        REG_TABLE_READY:  cfg_r.table_ready  <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // front: accept, range and ready checks, input queue
  bgl_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_command   (in_command),
    .in_area      (in_area),
    .in_deform    (in_deform),
    .in_cell_row  (in_cell_row),
    .in_cell_col  (in_cell_col),
    .in_cell_value(in_cell_value),
    .in_cell_valid(in_cell_valid),
    .cfg          (cfg_r),
    .head         (head),
    .head_vld     (head_vld),
    .pop          (pop)
  );

  // back: grid coordinates, corner reads, blend, result queue
  bgl_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .head      (head),
    .head_vld  (head_vld),
    .pop       (pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_value (out_value),
    .out_status(out_status)
  );

  // back never takes from an empty input queue
  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head_vld)
    else $error("pop from empty input queue");

  // a failed lookup carries a zero value
  a_bad_status_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != STATUS_OK)) |-> (out_value == 24'h0))
    else $error("nonzero value with failing status");

  // nothing comes out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule
`default_nettype wire
